// File: hw/rtl/sorted_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// sorted_priority_queue_assert
// assertion macros used by the sorted priority queue rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge out of reset
`define SPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorted_priority_queue: assertion failed");

// consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_priority_queue: assertion failed");

`else

`define SPQ_ASSERT(lbl, prop)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// types and codes of the sorted priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_O_W = 5;
  localparam int unsigned WORD_W  = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NOP    = 2'd3
  } spq_req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_e;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [WORD_W-1:0] sort_key;
    logic [WORD_W-1:0] payload;
    logic [POS_W-1:0]  position;
  } spq_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [WORD_W-1:0]  removed_key;
    logic [WORD_W-1:0]  removed_payload;
    logic [CNT_O_W-1:0] entry_count;
    logic               is_empty;
    logic [WORD_W-1:0]  head_key;
    logic [WORD_W-1:0]  head_payload;
  } spq_rsp_t;

  // per-transaction command broadcast to every cell
  typedef struct packed {
    logic             insert;
    logic             remove;
    logic [POS_W-1:0] position;
  } spq_cell_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted list: compares its key and trades with neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned CNT_W        = 5,
  parameter int unsigned IDX          = 0
) (
  input  wire logic                    clk_i,
  input  wire spq_cell_ctrl_t          ctrl_i,
  input  wire logic [CNT_W-1:0]        count_i,
  input  wire logic [KEY_BITS-1:0]     new_key_i,
  input  wire logic [PAYLOAD_BITS-1:0] new_payload_i,
  input  wire logic                    left_shift_i,
  input  wire logic [KEY_BITS-1:0]     left_key_i,
  input  wire logic [PAYLOAD_BITS-1:0] left_payload_i,
  input  wire logic [KEY_BITS-1:0]     right_key_i,
  input  wire logic [PAYLOAD_BITS-1:0] right_payload_i,
  output logic                         shift_o,
  output logic                         sel_o,
  output logic [KEY_BITS-1:0]          key_o,
  output logic [PAYLOAD_BITS-1:0]      payload_o
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic                    occupied;
  logic                    first_free;
  logic                    take_new;
  logic                    at_or_after;

  assign occupied    = MY_IDX < count_i;
  assign first_free  = MY_IDX == count_i;
  assign at_or_after = IDX >= int'(ctrl_i.position);
  assign sel_o       = IDX == int'(ctrl_i.position);

  // head moves aside only for a strictly smaller key, later slots for ties too
  always_comb begin
    if (IDX == 0) begin
      shift_o = occupied && (key_q > new_key_i);
    end else begin
      shift_o = occupied && (key_q >= new_key_i);
    end
  end

  assign take_new = !left_shift_i && (shift_o || first_free);

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (ctrl_i.insert) begin
      if (left_shift_i) begin
        key_d     = left_key_i;
        payload_d = left_payload_i;
      end else if (take_new) begin
        key_d     = new_key_i;
        payload_d = new_payload_i;
      end
    end else if (ctrl_i.remove && at_or_after) begin
      key_d     = right_key_i;
      payload_d = right_payload_i;
    end
  end

  // entries have no reset: slots beyond the count are never reported
  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// sorted list priority queue built as a chain of compare-and-shift cells
// ----------------------------------------------------------------------------
//
//   channel  | direction | type      | handshake
//   ---------+-----------+-----------+-------------------------
//   request  | in        | spq_req_t | in_valid_i / in_ready_o
//   response | out       | spq_rsp_t | out_valid_o / out_ready_i
//
// one transaction per cycle: every cell compares its key with the new key at
// once and takes from its left or right neighbor, so a request completes in
// the cycle it is accepted and its response is registered for the next cycle
// the response register parts the sides: a request is taken whenever the
// register is empty or being drained in the same cycle
// reset clears the entry count and the response valid; slot contents are
// never reported beyond the count and carry no reset
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire spq_req_t in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output spq_rsp_t      out_data_o
);

`include "sorted_priority_queue_assert.svh"

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // count and response register
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  spq_rsp_t         rsp_q, rsp_d;

  logic             in_acc;
  spq_req_e         req;
  logic [POS_W-1:0] pos_eff;
  logic             is_full;
  logic             pos_ok;
  logic             do_insert;
  logic             do_remove;
  spq_cell_ctrl_t   ctrl;

  logic [KEY_BITS-1:0]     new_key;
  logic [PAYLOAD_BITS-1:0] new_payload;

  // cell chain wiring
  logic [KEY_BITS-1:0]     key_w       [DEPTH];
  logic [PAYLOAD_BITS-1:0] payload_w   [DEPTH];
  logic                    shift_w     [DEPTH];
  logic                    sel_w       [DEPTH];
  logic [KEY_BITS-1:0]     left_key    [DEPTH];
  logic [PAYLOAD_BITS-1:0] left_pay    [DEPTH];
  logic                    left_shift  [DEPTH];
  logic [KEY_BITS-1:0]     right_key   [DEPTH];
  logic [PAYLOAD_BITS-1:0] right_pay   [DEPTH];

  logic [KEY_BITS-1:0]     removed_key;
  logic [PAYLOAD_BITS-1:0] removed_pay;
  logic [KEY_BITS-1:0]     head_key;
  logic [PAYLOAD_BITS-1:0] head_pay;
  logic [63:0]             count_wide;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign req        = spq_req_e'(in_data_i.req_type);

  assign new_key     = KEY_BITS'(in_data_i.sort_key);
  assign new_payload = PAYLOAD_BITS'(in_data_i.payload);

  // pop is a remove at the head
  assign pos_eff = (req == REQ_POP) ? '0 : in_data_i.position;
  assign is_full = count_q == FULL_CNT;
  assign pos_ok  = int'(pos_eff) < int'(count_q);

  assign do_insert = in_acc && (req == REQ_INSERT) && !is_full;
  assign do_remove = in_acc && ((req == REQ_POP) || (req == REQ_REMOVE)) && pos_ok;

  assign ctrl.insert   = do_insert;
  assign ctrl.remove   = do_remove;
  assign ctrl.position = pos_eff;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_shift[g] = 1'b0;
      assign left_key[g]   = '0;
      assign left_pay[g]   = '0;
    end else begin : g_mid
      assign left_shift[g] = shift_w[g-1];
      assign left_key[g]   = key_w[g-1];
      assign left_pay[g]   = payload_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      // last slot just falls out of the count on a remove
      assign right_key[g] = key_w[g];
      assign right_pay[g] = payload_w[g];
    end else begin : g_inner
      assign right_key[g] = key_w[g+1];
      assign right_pay[g] = payload_w[g+1];
    end

    spq_cell #(
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .CNT_W        (CNT_W),
      .IDX          (g)
    ) u_cell (
      .clk_i           (clk_i),
      .ctrl_i          (ctrl),
      .count_i         (count_q),
      .new_key_i       (new_key),
      .new_payload_i   (new_payload),
      .left_shift_i    (left_shift[g]),
      .left_key_i      (left_key[g]),
      .left_payload_i  (left_pay[g]),
      .right_key_i     (right_key[g]),
      .right_payload_i (right_pay[g]),
      .shift_o         (shift_w[g]),
      .sel_o           (sel_w[g]),
      .key_o           (key_w[g]),
      .payload_o       (payload_w[g])
    );
  end

  // pick out the removed slot, each cell flags whether it is the one
  always_comb begin
    removed_key = '0;
    removed_pay = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel_w[i]) begin
        removed_key = removed_key | key_w[i];
        removed_pay = removed_pay | payload_w[i];
      end
    end
  end

  // next count
  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + 1'b1;
    end else if (do_remove) begin
      count_d = count_q - 1'b1;
    end
  end

  // head after this transaction, worked out from the current slots
  always_comb begin
    head_key = key_w[0];
    head_pay = payload_w[0];
    if (do_insert && ((count_q == '0) || shift_w[0])) begin
      head_key = new_key;
      head_pay = new_payload;
    end else if (do_remove && (pos_eff == '0)) begin
      head_key = key_w[1];
      head_pay = payload_w[1];
    end
  end

  assign count_wide = 64'(count_d);

  always_comb begin
    rsp_d.status          = ST_DONE;
    rsp_d.removed_key     = '0;
    rsp_d.removed_payload = '0;
    if ((req == REQ_INSERT) && is_full) begin
      rsp_d.status = ST_FULL;
    end else if (((req == REQ_POP) || (req == REQ_REMOVE)) && !pos_ok) begin
      rsp_d.status = ST_EMPTY;
    end
    if (do_remove) begin
      rsp_d.removed_key     = WORD_W'(removed_key);
      rsp_d.removed_payload = WORD_W'(removed_pay);
    end
    rsp_d.entry_count  = count_wide[CNT_O_W-1:0];
    rsp_d.is_empty     = count_d == '0;
    rsp_d.head_key     = (count_d == '0) ? '0 : WORD_W'(head_key);
    rsp_d.head_payload = (count_d == '0) ? '0 : WORD_W'(head_pay);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // response payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  // count never runs past the chain length
  `SPQ_ASSERT(a_count_range, count_q <= FULL_CNT)
  // list stays ordered at the head
  `SPQ_ASSERT(a_head_order, (count_q < CNT_W'(2)) || (key_w[0] <= key_w[1]))
  // an accepted insert into a non-full list grows it by one
  `SPQ_ASSERT_NEXT(a_insert_grows, do_insert, count_q == $past(count_q) + 1'b1)
  // an insert into a full list is reported as dropped
  `SPQ_ASSERT_NEXT(a_full_drop, in_acc && (req == REQ_INSERT) && is_full,
                   (rsp_q.status == ST_FULL) && $stable(count_q))
  // every accepted transaction leaves a response behind
  `SPQ_ASSERT_NEXT(a_rsp_follows, in_acc, out_valid_q)

endmodule

`default_nettype wire

// File: tb/spq_order_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_order_checker
// watches both channels of the sorted priority queue, keeps its own sorted
// list of entries, predicts each response and compares it field by field
// ----------------------------------------------------------------------------

module spq_order_checker
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  spq_req_t in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  spq_rsp_t out_data_i,
  output int       pending_o,
  output int       fail_count_o
);

  localparam int unsigned PRINT_CAP = 200;

  logic [WORD_W-1:0] key_mem [DEPTH];
  logic [WORD_W-1:0] pay_mem [DEPTH];
  int unsigned       fill = 0;
  spq_rsp_t          rsp_due_q [$];
  int unsigned       rsp_seen = 0;
  int                mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("%0t spq checker: %s", $time, msg);
    end
  endtask

  // applies one request to the local list and returns the response it earns
  function automatic spq_rsp_t queue_apply(input spq_req_t req);
    spq_rsp_t    rsp;
    int unsigned at;
    int unsigned i;
    int          take;
    rsp  = '0;
    take = -1;
    rsp.status = ST_DONE;
    case (spq_req_e'(req.req_type))
      REQ_INSERT: begin
        if (fill >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          // head is only displaced by a strictly smaller key
          if (fill == 0 || key_mem[0] > req.sort_key) begin
            at = 0;
          end else begin
            at = 1;
            while (at < fill && key_mem[at] < req.sort_key) at++;
          end
          for (i = fill; i > at; i--) begin
            key_mem[i] = key_mem[i-1];
            pay_mem[i] = pay_mem[i-1];
          end
          key_mem[at] = req.sort_key;
          pay_mem[at] = req.payload;
          fill++;
        end
      end
      REQ_POP: begin
        if (fill == 0) rsp.status = ST_EMPTY;
        else take = 0;
      end
      REQ_REMOVE: begin
        if (req.position >= fill) rsp.status = ST_EMPTY;
        else take = req.position;
      end
      default: ;
    endcase
    if (take >= 0) begin
      rsp.removed_key     = key_mem[take];
      rsp.removed_payload = pay_mem[take];
      for (i = take; i + 1 < fill; i++) begin
        key_mem[i] = key_mem[i+1];
        pay_mem[i] = pay_mem[i+1];
      end
      fill--;
    end
    rsp.entry_count = fill[CNT_O_W-1:0];
    rsp.is_empty    = (fill == 0);
    if (fill != 0) begin
      rsp.head_key     = key_mem[0];
      rsp.head_payload = pay_mem[0];
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    spq_rsp_t want;
    if (!rst_ni) begin
      fill = 0;
      rsp_due_q.delete();
      pending_o <= 0;
    end else begin
      // responses first: one accepted now belongs to an older request
      if (out_valid_i && out_ready_i) begin
        if (rsp_due_q.size() == 0) begin
          report_mismatch($sformatf("response %0d with no request pending", rsp_seen));
        end else begin
          want = rsp_due_q.pop_front();
          if (out_data_i.status !== want.status)
            report_mismatch($sformatf("response %0d status: got %h want %h",
                                      rsp_seen, out_data_i.status, want.status));
          if (out_data_i.removed_key !== want.removed_key)
            report_mismatch($sformatf("response %0d removed_key: got %h want %h",
                                      rsp_seen, out_data_i.removed_key, want.removed_key));
          if (out_data_i.removed_payload !== want.removed_payload)
            report_mismatch($sformatf("response %0d removed_payload: got %h want %h",
                                      rsp_seen, out_data_i.removed_payload,
                                      want.removed_payload));
          if (out_data_i.entry_count !== want.entry_count)
            report_mismatch($sformatf("response %0d entry_count: got %h want %h",
                                      rsp_seen, out_data_i.entry_count, want.entry_count));
          if (out_data_i.is_empty !== want.is_empty)
            report_mismatch($sformatf("response %0d is_empty: got %h want %h",
                                      rsp_seen, out_data_i.is_empty, want.is_empty));
          if (out_data_i.head_key !== want.head_key)
            report_mismatch($sformatf("response %0d head_key: got %h want %h",
                                      rsp_seen, out_data_i.head_key, want.head_key));
          if (out_data_i.head_payload !== want.head_payload)
            report_mismatch($sformatf("response %0d head_payload: got %h want %h",
                                      rsp_seen, out_data_i.head_payload, want.head_payload));
        end
        rsp_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        rsp_due_q.push_back(queue_apply(in_data_i));
      end
      pending_o <= rsp_due_q.size();
    end
  end

endmodule

// File: tb/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// drives insert, pop, remove and no-op requests into the sorted priority
// queue under varying backpressure and leaves all checking to the checker
// ----------------------------------------------------------------------------

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned PHASE_ITEMS = 617;     // items in each of three random phases
  localparam int unsigned GOAL_PERIOD = 32;      // items between new fill goals
  localparam int unsigned HOLD_CYCLES = 120;     // long receiver hold-off
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  spq_req_t    in_data   = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  spq_rsp_t    out_data;

  int          pending;
  int          fail_count;
  int          send_idle = 0;      // percent of cycles the sender holds back
  int          recv_idle = 0;      // percent of cycles the receiver stalls
  logic        hold_req  = 1'b0;   // toggled to start a long hold-off
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles    = 0;
  int unsigned fill_est  = 0;      // entry count as the stimulus sees it
  int unsigned fill_goal = 0;      // level the random stream drifts toward

  always #1 clk = ~clk;

  sorted_priority_queue #(
    .DEPTH        (QUEUE_DEPTH),
    .KEY_BITS     (32),
    .PAYLOAD_BITS (32)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  spq_order_checker #(
    .DEPTH (QUEUE_DEPTH)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off whenever hold_req toggles
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic spq_req_t build_request(input spq_req_e kind, input logic [31:0] key,
                                             input logic [31:0] pay, input logic [3:0] pos);
    spq_req_t r;
    r.req_type = kind;
    r.sort_key = key;
    r.payload  = pay;
    r.position = pos;
    return r;
  endfunction

  // keys crowd into zero, all ones and small or top-bit values so equal keys are common
  function automatic logic [31:0] rand_key();
    logic [31:0] k;
    case ($urandom_range(9))
      0:       k = '0;
      1:       k = '1;
      2, 3, 4: k = $urandom_range(15);
      5:       k = 32'h8000_0000 | $urandom_range(3);
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // random request steered toward fill_goal, with some stray traffic mixed in
  function automatic spq_req_t make_request();
    spq_req_t r;
    int       pick;
    r    = build_request(REQ_NOP, rand_key(), $urandom, $urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 5) begin
      r.req_type = REQ_NOP;
    end else if (pick < 12) begin
      // stray remove, often past the last entry
      r.req_type = REQ_REMOVE;
    end else if ($urandom_range(9) < ((fill_est < fill_goal) ? 8 : 2)) begin
      r.req_type = REQ_INSERT;
    end else if (fill_est == 0 || $urandom_range(1) == 0) begin
      r.req_type = REQ_POP;
    end else begin
      r.req_type = REQ_REMOVE;
      r.position = $urandom_range(fill_est - 1);
    end
    return r;
  endfunction

  // offer one transaction and hold it until the block takes it
  task automatic push_request(input spq_req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    case (spq_req_e'(r.req_type))
      REQ_INSERT: if (fill_est < QUEUE_DEPTH) fill_est++;
      REQ_POP:    if (fill_est != 0) fill_est--;
      REQ_REMOVE: if (r.position < fill_est) fill_est--;
      default:    ;
    endcase
  endtask

  // sender pause until every outstanding response has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 31;
    recv_idle <= 71;

    // directed: empty-list corner cases
    push_request(build_request(REQ_POP,    '0, '0, 4'd0));
    push_request(build_request(REQ_REMOVE, '0, '0, 4'd0));
    push_request(build_request(REQ_REMOVE, '1, '1, 4'd15));
    push_request(build_request(REQ_NOP,    '1, '1, 4'd15));
    // extreme keys and payloads; smaller key displaces the head
    push_request(build_request(REQ_INSERT, '1, '0, 4'd0));
    push_request(build_request(REQ_INSERT, '0, '1, 4'd0));
    // key equal to the head lands behind it
    push_request(build_request(REQ_INSERT, '0, 32'h0000_0001, 4'd0));
    push_request(build_request(REQ_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 4'd0));
    // remove the last entry, then one past the end
    push_request(build_request(REQ_REMOVE, '0, '0, 4'd3));
    push_request(build_request(REQ_REMOVE, '1, '1, 4'd3));
    // remove at position zero behaves as a pop
    push_request(build_request(REQ_REMOVE, '0, '0, 4'd0));
    push_request(build_request(REQ_NOP,    '0, '0, 4'd0));
    push_request(build_request(REQ_POP,    '0, '0, 4'd0));
    push_request(build_request(REQ_POP,    '0, '0, 4'd0));
    drain();

    // long receiver hold-off while inserts keep coming: the response register
    // backs up, the input stalls, and the list runs into full
    send_idle = 0;
    hold_req <= ~hold_req;
    repeat (QUEUE_DEPTH + 8) push_request(build_request(REQ_INSERT, rand_key(), $urandom, '0));
    push_request(build_request(REQ_REMOVE, '0, '0, 4'd15));
    push_request(build_request(REQ_REMOVE, '0, '0, 4'd0));
    push_request(build_request(REQ_POP,    '0, '0, 4'd0));
    drain();

    // random phases: receiver mostly idle, sender mostly idle, then neither
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 31; recv_idle <= 71; end
        1: begin send_idle = 71; recv_idle <= 31; end
        default: begin send_idle = 0; recv_idle <= 0; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % GOAL_PERIOD == 0) fill_goal = $urandom_range(QUEUE_DEPTH);
        push_request(make_request());
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
tb/spq_order_checker.sv
tb/tb_sorted_priority_queue.sv
